>>> src/p2sa_pkg.sv
// Shared types, sizes and helpers for the power-of-two segregated allocator.
// Used by pow2_segregated_allocator_top and its testbench; no dependencies.
package p2sa_pkg;

  localparam int ADDR_BITS   = 20;
  localparam int NUM_CLASSES = 21;
  localparam int STACK_DEPTH = 16;

  // Fixed field widths of the request and result transactions.
  localparam int SIZE_W = 21;
  localparam int OFFS_W = 20;
  localparam int SUM_W  = SIZE_W + 1;

  // A class index can reach SIZE_W for the largest request.
  localparam int CLS_W   = $clog2(SIZE_W + 1);
  localparam int CIDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
  localparam int MEM_AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [OFFS_W-1:0] OFFS_MASK = OFFS_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [SUM_W-1:0]  SPACE_CAP =
    SUM_W'(64'd1 << ((ADDR_BITS < SIZE_W) ? ADDR_BITS : SIZE_W));
  localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(1048576);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_BIG  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Ceiling log2 of the size, with a size of zero treated as one.
  function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] m;
    logic [CLS_W-1:0]  c;
    m = (n == '0) ? '0 : n - SIZE_W'(1);
    c = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) c = CLS_W'(i + 1);
    end
    return c;
  endfunction

endpackage

>>> src/p2sa_stack_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the class stacks.
// Read data is registered and holds until the next read; no dependencies.
module p2sa_stack_ram #(
  parameter int DEPTH = 336,
  parameter int WIDTH = 20,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/pow2_segregated_allocator_top.sv
// Power-of-two segregated free-list allocator, top level.
// Depends on p2sa_pkg and p2sa_stack_ram.
//
// Requests arrive on the in_ channel (kind, request_bytes, block_offset) and
// each one yields exactly one result on the out_ channel (block_offset_out,
// granted_bytes, status). A transaction moves on a rising edge with valid
// high and stall low. An allocation pops the newest freed block of its size
// class or carves from the bump pointer; a free pushes onto its class stack
// unless it is full. The free stacks live in one synchronous RAM with a
// registered read; per-class counts and the bump pointer are flip-flops.
// A request passes through accept and update, plus a pop step when an
// allocation pops the stack, which takes the RAM read data. A new
// request is taken once the previous one has written its result register.
// The result register holds while out_stall is high; the block then waits
// before writing the next result, so nothing is lost. Reset clears counts,
// the bump pointer and pool_size (to 1 MiB) at once; stack entries are
// never read before they are written. The user must write pool_size via
// cfg_write_en/cfg_write_data while the block is idle; it is not enforced.
module pow2_segregated_allocator_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_en,
  input  logic [p2sa_pkg::SIZE_W-1:0]  cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [p2sa_pkg::SIZE_W-1:0]  request_bytes,
  input  logic [p2sa_pkg::OFFS_W-1:0]  block_offset,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [p2sa_pkg::OFFS_W-1:0]  block_offset_out,
  output logic [p2sa_pkg::SIZE_W-1:0]  granted_bytes,
  output logic [1:0]                   status
);
  import p2sa_pkg::*;

  state_t state, state_next;

  logic [SIZE_W-1:0] pool_size;
  logic [SIZE_W-1:0] bump_offset;
  logic [CNT_W-1:0]  class_counts [NUM_CLASSES];

  // Registered request.
  logic              req_kind;
  logic [CLS_W-1:0]  req_cls;
  logic              req_big;
  logic [OFFS_W-1:0] req_offs;

  logic [CLS_W-1:0]  in_cls;
  logic [CIDX_W-1:0] cls_idx;
  logic [CNT_W-1:0]  cur_cnt;
  logic [SUM_W-1:0]  block;
  logic [SUM_W-1:0]  eff_pool;
  logic [SUM_W-1:0]  bump_sum;
  logic              slot_free;
  logic              accept;

  // Datapath controls from the output decode.
  logic              res_load;
  logic [OFFS_W-1:0] res_offs;
  logic [SIZE_W-1:0] res_grant;
  status_t           res_status;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_next;
  logic              bump_we;
  logic              mem_we;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_addr;
  logic [OFFS_W-1:0] mem_rdata;

  assign in_cls    = size_class(request_bytes);
  assign cls_idx   = req_cls[CIDX_W-1:0];
  assign cur_cnt   = class_counts[cls_idx];
  assign block     = SUM_W'(1) << req_cls;
  assign eff_pool  = (SUM_W'(pool_size) < SPACE_CAP) ? SUM_W'(pool_size) : SPACE_CAP;
  assign bump_sum  = SUM_W'(bump_offset) + block;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = rst || (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          if (!req_big && req_kind == KIND_ALLOC && cur_cnt != '0) begin
            state_next = S_POP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_POP: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_load   = 1'b0;
    res_offs   = '0;
    res_grant  = '0;
    res_status = ST_OK;
    cnt_we     = 1'b0;
    cnt_next   = cur_cnt;
    bump_we    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = MEM_AW'(cls_idx) * MEM_AW'(STACK_DEPTH) + MEM_AW'(cur_cnt);
    unique case (state)
      S_IDLE: begin
      end
      S_EXEC: begin
        if (slot_free) begin
          if (req_big) begin
            res_load   = 1'b1;
            res_status = ST_BIG;
          end else if (req_kind == KIND_FREE) begin
            res_load = 1'b1;
            if (cur_cnt >= CNT_W'(STACK_DEPTH)) begin
              res_status = ST_FULL;
            end else begin
              mem_we   = 1'b1;
              cnt_we   = 1'b1;
              cnt_next = cur_cnt + CNT_W'(1);
            end
          end else if (cur_cnt != '0) begin
            // Pop the newest entry; the result is formed once the RAM answers.
            mem_re   = 1'b1;
            cnt_we   = 1'b1;
            cnt_next = cur_cnt - CNT_W'(1);
            mem_addr = MEM_AW'(cls_idx) * MEM_AW'(STACK_DEPTH) + MEM_AW'(cnt_next);
          end else begin
            res_load = 1'b1;
            // A bump pointer at or past the pool end always fails here,
            // since every block is at least one byte.
            if (bump_sum <= eff_pool) begin
              bump_we   = 1'b1;
              res_offs  = OFFS_W'(bump_offset) & OFFS_MASK;
              res_grant = SIZE_W'(block);
            end else begin
              res_status = ST_OOM;
            end
          end
        end
      end
      S_POP: begin
        if (slot_free) begin
          res_load  = 1'b1;
          res_offs  = mem_rdata & OFFS_MASK;
          res_grant = SIZE_W'(block);
        end
      end
      default: begin
      end
    endcase
  end

  // Counts change in the update cycle, and the next request reaches that
  // cycle only by way of the idle state, so RAM accesses never overlap.
  p2sa_stack_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (OFFS_W),
    .AW    (MEM_AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (req_offs & OFFS_MASK),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pool_size   <= POOL_RESET;
      bump_offset <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_write_en) pool_size <= cfg_write_data;
      if (bump_we) bump_offset <= bump_sum[SIZE_W-1:0];
      if (cnt_we) class_counts[cls_idx] <= cnt_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_cls  <= in_cls;
      req_big  <= (int'(in_cls) >= NUM_CLASSES);
      req_offs <= block_offset;
    end
    if (res_load) begin
      block_offset_out <= res_offs;
      granted_bytes    <= res_grant;
      status           <= res_status;
    end
  end

  // A nonzero grant only ever accompanies a successful allocation.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && granted_bytes != '0 |-> status == ST_OK)
    else $error("grant reported with a failing status");

  // An accepted request always moves on to its update cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted request did not reach the update cycle");

  // The pop cycle is only entered from the update cycle or held.
  assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> $past(state) == S_EXEC || $past(state) == S_POP)
    else $error("pop cycle entered without a stack read");

  // A class never holds more entries than its stack has room for.
  assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && !req_big |-> cur_cnt <= CNT_W'(STACK_DEPTH))
    else $error("class count exceeds stack depth");

  // The bump pointer never passes the addressable space.
  assert property (@(posedge clk) disable iff (rst)
    SUM_W'(bump_offset) <= SPACE_CAP)
    else $error("bump pointer beyond address space");

  // A result is never overwritten while the receiver stalls it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !res_load)
    else $error("stalled result overwritten");

endmodule

>>> verif/tb_pow2_segregated_allocator_top.sv
// Self-checking testbench for pow2_segregated_allocator_top: predicts every allocation and free
// and compares the results while both channels idle and stall at random.
// Depends on p2sa_pkg and the allocator RTL in src.
module tb_pow2_segregated_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import p2sa_pkg::*;

  typedef struct {
    logic [OFFS_W-1:0] offs;
    logic [SIZE_W-1:0] bytes;
    status_t           st;
  } grant_t;

  typedef struct {
    logic [OFFS_W-1:0] offs;
    logic [SIZE_W-1:0] bytes;
  } block_t;

  // Tracks the allocator state and the grants that are still owed by the block.
  class pool_tracker;
    logic [SIZE_W-1:0] pool_bytes;
    longint unsigned   bump;
    logic [OFFS_W-1:0] free_stack[NUM_CLASSES][STACK_DEPTH];
    int unsigned       depth_of[NUM_CLASSES];
    grant_t            pending_grants[$];
    block_t            live_blocks[$];
    int                mismatch_count;

    function new();
      pool_bytes = POOL_RESET;
      bump = 0;
      mismatch_count = 0;
      foreach (depth_of[c]) depth_of[c] = 0;
    endfunction

    // Smallest c with 2**c >= n; a size of zero lands in class 0 as well.
    function int unsigned ceil_log2(logic [SIZE_W-1:0] n);
      int unsigned c;
      c = 0;
      while (c < 40 && (longint'(1) << c) < longint'(n)) c++;
      return c;
    endfunction

    function void note_request(logic k, logic [SIZE_W-1:0] nbytes, logic [OFFS_W-1:0] offs);
      int unsigned     cls;
      grant_t          g;
      longint unsigned blk;
      longint unsigned eff;
      longint unsigned rem;
      cls = ceil_log2(nbytes);
      g.offs = '0;
      g.bytes = '0;
      g.st = ST_OK;
      if (cls >= NUM_CLASSES) begin
        g.st = ST_BIG;
      end else if (k == KIND_ALLOC) begin
        blk = longint'(1) << cls;
        if (depth_of[cls] > 0) begin
          depth_of[cls]--;
          g.offs = free_stack[cls][depth_of[cls]];
          g.bytes = SIZE_W'(blk);
        end else begin
          eff = pool_bytes;
          if (eff > (longint'(1) << ADDR_BITS)) eff = longint'(1) << ADDR_BITS;
          rem = (bump < eff) ? eff - bump : 0;
          if (blk <= rem) begin
            g.offs = OFFS_W'(bump);
            g.bytes = SIZE_W'(blk);
            bump = (bump + blk) & ((longint'(1) << SIZE_W) - 1);
          end else begin
            g.st = ST_OOM;
          end
        end
        if (g.st == ST_OK) live_blocks.push_back('{g.offs, g.bytes});
      end else begin
        if (depth_of[cls] >= STACK_DEPTH) begin
          g.st = ST_FULL;
        end else begin
          free_stack[cls][depth_of[cls]] = offs & OFFS_MASK;
          depth_of[cls]++;
        end
      end
      pending_grants.push_back(g);
    endfunction

    function void check_grant(logic [OFFS_W-1:0] offs, logic [SIZE_W-1:0] nbytes,
                              logic [1:0] st);
      grant_t exp_g;
      if (pending_grants.size() == 0) begin
        $error("result transaction with no request waiting: offset %0h bytes %0d status %0d",
               offs, nbytes, st);
        mismatch_count++;
        return;
      end
      exp_g = pending_grants.pop_front();
      if (offs !== exp_g.offs) begin
        $error("block_offset_out: expected %0h, got %0h", exp_g.offs, offs);
        mismatch_count++;
      end
      if (nbytes !== exp_g.bytes) begin
        $error("granted_bytes: expected %0d, got %0d", exp_g.bytes, nbytes);
        mismatch_count++;
      end
      if (st !== exp_g.st) begin
        $error("status: expected %s, got %0d", exp_g.st.name(), st);
        mismatch_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_write_en = 1'b0;
  logic [SIZE_W-1:0] cfg_write_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              kind = KIND_ALLOC;
  logic [SIZE_W-1:0] request_bytes = '0;
  logic [OFFS_W-1:0] block_offset = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OFFS_W-1:0] block_offset_out;
  logic [SIZE_W-1:0] granted_bytes;
  logic [1:0]        status;

  pool_tracker board;
  int          burst_left = 8;
  int          stall_left = 0;
  int          stall_mode = 0;
  int          mode_cycles = 0;

  pow2_segregated_allocator_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .kind             (kind),
    .request_bytes    (request_bytes),
    .block_offset     (block_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .block_offset_out (block_offset_out),
    .granted_bytes    (granted_bytes),
    .status           (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: checks every accepted result and stalls in modes that change at
  // random intervals (no stall, scattered stalls, long stretches).
  always @(posedge clk) begin
    if (out_valid && !out_stall && !rst) board.check_grant(block_offset_out, granted_bytes, status);
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_cycles == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_cycles = $urandom_range(40, 160);
      end else begin
        mode_cycles--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_mode == 1) begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end else if (stall_mode == 2 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic k, logic [SIZE_W-1:0] nbytes, logic [OFFS_W-1:0] offs);
    in_valid <= 1'b1;
    kind <= k;
    request_bytes <= nbytes;
    block_offset <= offs;
    do @(posedge clk); while (in_stall);
    board.note_request(k, nbytes, offs);
  endtask

  // Ends a burst of back-to-back transactions with a random gap.
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool_size(logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    board.pool_bytes = value;
  endtask

  // Mostly small classes, now and then a large one; a size of zero shows up too.
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned c;
    c = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(0, 10);
    if (c == 0) return SIZE_W'($urandom_range(0, 1));
    return SIZE_W'($urandom_range((1 << (c - 1)) + 1, 1 << c));
  endfunction

  task automatic random_request();
    int unsigned       sel;
    int unsigned       idx;
    block_t            blk;
    logic [SIZE_W-1:0] nbytes;
    sel = $urandom_range(0, 99);
    if (sel >= 40 && sel < 80 && board.live_blocks.size() > 0) begin
      // Well-formed free of a block handed out earlier, sometimes with an
      // unrounded size from the same class.
      idx = $urandom_range(0, board.live_blocks.size() - 1);
      blk = board.live_blocks[idx];
      board.live_blocks.delete(idx);
      nbytes = blk.bytes;
      if (nbytes > 1 && $urandom_range(0, 1) == 1)
        nbytes = SIZE_W'($urandom_range(blk.bytes / 2 + 1, blk.bytes));
      send_item(KIND_FREE, nbytes, blk.offs);
    end else if (sel >= 80 && sel < 90) begin
      send_item(KIND_FREE, pick_size(), OFFS_W'($urandom()));
    end else if (sel >= 90 && sel < 95) begin
      send_item(logic'($urandom_range(0, 1)), SIZE_W'($urandom_range(1048577, 2097151)),
                OFFS_W'($urandom()));
    end else if (sel >= 95) begin
      send_item(KIND_FREE, SIZE_W'($urandom_range(0, 4)), OFFS_W'($urandom()));
    end else begin
      send_item(KIND_ALLOC, pick_size(), OFFS_W'($urandom()));
    end
    pace_sender();
  endtask

  task automatic run_random(int count);
    repeat (count) random_request();
  endtask

  task automatic run_directed();
    send_item(KIND_ALLOC, SIZE_W'(0), '0);
    send_item(KIND_ALLOC, SIZE_W'(1), '1);
    send_item(KIND_ALLOC, SIZE_W'(3), '0);
    send_item(KIND_ALLOC, SIZE_W'(1048577), '0);
    send_item(KIND_ALLOC, SIZE_W'(2097151), '1);
    send_item(KIND_FREE, SIZE_W'(2097151), '1);
    // A whole-space block goes back onto its stack and is reused.
    send_item(KIND_FREE, SIZE_W'(1048576), '1);
    pace_sender();
    send_item(KIND_ALLOC, SIZE_W'(1048576), '0);
    send_item(KIND_ALLOC, SIZE_W'(1048576), '0);
    // Seventeen frees of the smallest class: the last finds its stack full.
    for (int i = 0; i < STACK_DEPTH + 1; i++) begin
      send_item(KIND_FREE, SIZE_W'(i % 2), (i == 0) ? '0 : OFFS_W'($urandom()));
      pace_sender();
    end
    send_item(KIND_ALLOC, SIZE_W'(1), '0);
    send_item(KIND_ALLOC, SIZE_W'(0), '0);
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    write_pool_size(SIZE_W'(0));
    run_random(130);
    write_pool_size(SIZE_W'(2097151));
    run_random(140);
    // Shrink the pool below what has already been carved.
    write_pool_size(SIZE_W'(board.bump >> 1));
    run_random(130);
    write_pool_size(POOL_RESET);
    run_random(130);
    wait_drained();
    repeat (10) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
src/p2sa_pkg.sv
src/p2sa_stack_ram.sv
src/pow2_segregated_allocator_top.sv
verif/tb_pow2_segregated_allocator_top.sv
